// ===== src/rbf_pkg.sv =====
// Package for the reconnect backoff state machine.
// Holds the state encoding, register indexes, field widths, result type and
// the backoff function. No dependencies.
`default_nettype none

package rbf_pkg;

	localparam int NOW_W   = 32;
	localparam int DELAY_W = 16;
	localparam int RETRY_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY  = 1'd1;

	localparam logic [DELAY_W-1:0] BASE_DELAY_RST = 16'd2000;
	localparam logic [DELAY_W-1:0] MAX_DELAY_RST  = 16'd30000;
	localparam logic [RETRY_W-1:0] RETRY_MAX      = 8'd255;

	typedef enum logic [1:0] {
		ST_DISCONNECTED = 2'd0,
		ST_CONNECTING   = 2'd1,
		ST_CONNECTED    = 2'd2,
		ST_FAILED       = 2'd3
	} link_state_t;

	typedef struct packed {
		link_state_t        link_state;
		logic [RETRY_W-1:0] retries;
		logic               attempt_used;
		logic               became_connected;
		logic               link_lost;
		logic [NOW_W-1:0]   wait_until_ms;
		logic [DELAY_W-1:0] delay_ms;
	} rbf_result_t;

	function automatic logic [DELAY_W-1:0] backoff(
		input logic [DELAY_W-1:0] base,
		input logic [DELAY_W-1:0] ceil,
		input logic [RETRY_W-1:0] tries
	);
		logic [2*DELAY_W-2:0] shifted;
		logic [DELAY_W-1:0]   res;
		shifted = {{(DELAY_W-1){1'b0}}, base} << tries[3:0];
		if (base == '0) begin
			res = '0;
		end else if (tries >= RETRY_W'(DELAY_W)) begin
			res = ceil;
		end else if (shifted < {{(DELAY_W-1){1'b0}}, ceil}) begin
			res = shifted[DELAY_W-1:0];
		end else begin
			res = ceil;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== src/rbf_in_if.sv =====
// Tick channel: valid/ready handshake with time and link inputs.
// Depends on rbf_pkg.
`default_nettype none

interface rbf_in_if import rbf_pkg::*;;
	logic             valid;
	logic             ready;
	logic [NOW_W-1:0] now_ms;
	logic             connect_ok;
	logic             link_up;

	modport source (output valid, now_ms, connect_ok, link_up, input ready);
	modport sink   (input valid, now_ms, connect_ok, link_up, output ready);
endinterface

`default_nettype wire

// ===== src/rbf_out_if.sv =====
// Result channel: valid/ready handshake with state, retry and deadline fields.
// Depends on rbf_pkg.
`default_nettype none

interface rbf_out_if import rbf_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         link_state;
	logic [RETRY_W-1:0] retries;
	logic               attempt_used;
	logic               became_connected;
	logic               link_lost;
	logic [NOW_W-1:0]   wait_until_ms;
	logic [DELAY_W-1:0] delay_ms;

	modport source (output valid, link_state, retries, attempt_used, became_connected,
		link_lost, wait_until_ms, delay_ms, input ready);
	modport sink   (input valid, link_state, retries, attempt_used, became_connected,
		link_lost, wait_until_ms, delay_ms, output ready);
endinterface

`default_nettype wire

// ===== src/reconnect_backoff_fsm.sv =====
// Connection manager with exponential reconnect backoff, one tick per transfer.
// Depends on rbf_pkg, rbf_in_if and rbf_out_if.
//
//   channel | dir | handshake    | payload
//   tick    | in  | valid/ready  | now_ms, connect_ok, link_up
//   result  | out | valid/ready  | link_state, retries, attempt_used, became_connected,
//           |     |              | link_lost, wait_until_ms, delay_ms
//   wr_*    | in  | wr_en only   | wr_index, wr_data
//
// One tick per cycle sustained while the result channel is not stalled.
// Stage s1 registers the tick; the state update and result register follow it.
// A stalled result holds; while it waits, s1 still takes a tick only if s1 is empty.
// Reset clears the state to disconnected, retries and deadline to zero, registers
// to their defaults.
`default_nettype none

module reconnect_backoff_fsm import rbf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	rbf_in_if.sink                     tick,
	rbf_out_if.source                  result,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	logic [DELAY_W-1:0] base_delay_q, max_delay_q;
	link_state_t        state_q, state_d;
	logic [RETRY_W-1:0] retry_q, retry_d, retry_inc, tries;
	logic [NOW_W-1:0]   deadline_q, deadline_d;

	logic               tick_vld_s1;
	logic [NOW_W-1:0]   now_s1;
	logic               ok_s1, up_s1;

	logic               res_vld_q;
	rbf_result_t        res_q, res_d;
	logic               advance;
	logic [DELAY_W-1:0] delay;
	logic               reached;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_delay_q <= BASE_DELAY_RST;
			max_delay_q  <= MAX_DELAY_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE_DELAY: base_delay_q <= wr_data[DELAY_W-1:0];
				REG_MAX_DELAY:  max_delay_q  <= wr_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance    = !res_vld_q || result.ready;
	assign tick.ready = !tick_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_vld_s1 <= 1'b0;
		end else if (tick.ready) begin
			tick_vld_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			now_s1 <= tick.now_ms;
			ok_s1  <= tick.connect_ok;
			up_s1  <= tick.link_up;
		end
	end

	assign retry_inc = (retry_q == RETRY_MAX) ? retry_q : retry_q + 1'b1;
	assign tries     = (state_q == ST_CONNECTING) ? retry_inc : retry_q;
	assign delay     = backoff(base_delay_q, max_delay_q, tries);
	assign reached   = now_s1 >= deadline_q;

	always_comb begin
		state_d    = state_q;
		retry_d    = retry_q;
		deadline_d = deadline_q;
		res_d      = '0;
		case (state_q)
			ST_DISCONNECTED: begin
				if (reached) state_d = ST_CONNECTING;
			end
			ST_CONNECTING: begin
				res_d.attempt_used = 1'b1;
				if (ok_s1) begin
					state_d    = ST_CONNECTED;
					retry_d    = '0;
					deadline_d = '0;
					res_d.became_connected = 1'b1;
				end else begin
					state_d    = ST_FAILED;
					retry_d    = retry_inc;
					deadline_d = now_s1 + {{(NOW_W-DELAY_W){1'b0}}, delay};
					res_d.delay_ms = delay;
				end
			end
			ST_CONNECTED: begin
				if (!up_s1) begin
					state_d    = ST_DISCONNECTED;
					deadline_d = now_s1 + {{(NOW_W-DELAY_W){1'b0}}, delay};
					res_d.delay_ms  = delay;
					res_d.link_lost = 1'b1;
				end
			end
			ST_FAILED: begin
				if (reached) state_d = ST_DISCONNECTED;
			end
			default: state_d = ST_DISCONNECTED;
		endcase
		res_d.link_state    = state_d;
		res_d.retries       = retry_d;
		res_d.wait_until_ms = deadline_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_DISCONNECTED;
			retry_q    <= '0;
			deadline_q <= '0;
			res_vld_q  <= 1'b0;
		end else if (advance) begin
			res_vld_q <= tick_vld_s1;
			if (tick_vld_s1) begin
				state_q    <= state_d;
				retry_q    <= retry_d;
				deadline_q <= deadline_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tick_vld_s1) begin
			res_q <= res_d;
		end
	end

	assign result.valid            = res_vld_q;
	assign result.link_state       = res_q.link_state;
	assign result.retries          = res_q.retries;
	assign result.attempt_used     = res_q.attempt_used;
	assign result.became_connected = res_q.became_connected;
	assign result.link_lost        = res_q.link_lost;
	assign result.wait_until_ms    = res_q.wait_until_ms;
	assign result.delay_ms         = res_q.delay_ms;

endmodule

`default_nettype wire

// ===== src/rbf_checker.sv =====
// Port-level checks on the result channel of the reconnect backoff state machine.
// Depends on rbf_pkg; bound to reconnect_backoff_fsm below.
`default_nettype none

module rbf_checker import rbf_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire logic [1:0]         link_state,
	input wire logic [RETRY_W-1:0] retries,
	input wire logic               attempt_used,
	input wire logic               became_connected,
	input wire logic               link_lost,
	input wire logic [NOW_W-1:0]   wait_until_ms,
	input wire logic [DELAY_W-1:0] delay_ms
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(link_state) && $stable(retries)
			&& $stable(wait_until_ms) && $stable(delay_ms))
		else $error("result changed while stalled");

	a_connect: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && became_connected |-> attempt_used && link_state == ST_CONNECTED
			&& retries == '0 && wait_until_ms == '0)
		else $error("bad connect result");

	a_lost: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && link_lost |-> !attempt_used && link_state == ST_DISCONNECTED
			&& retries == '0)
		else $error("bad link loss result");

	a_attempt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && attempt_used |-> (link_state == ST_CONNECTED && became_connected)
			|| (link_state == ST_FAILED && retries != '0))
		else $error("attempt left wrong state");

	a_delay: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && delay_ms != '0 |-> link_lost || (attempt_used && !became_connected))
		else $error("delay without backoff event");

endmodule

bind reconnect_backoff_fsm rbf_checker u_rbf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.link_state       (result.link_state),
	.retries          (result.retries),
	.attempt_used     (result.attempt_used),
	.became_connected (result.became_connected),
	.link_lost        (result.link_lost),
	.wait_until_ms    (result.wait_until_ms),
	.delay_ms         (result.delay_ms)
);

`default_nettype wire

// ===== sim/reconnect_backoff_fsm_tb.sv =====
// Self-checking testbench for reconnect_backoff_fsm: drives ticks and register
// writes, predicts each result in a scoreboard class and checks it field by field.
// Depends on rbf_pkg, rbf_in_if, rbf_out_if and the reconnect_backoff_fsm RTL.
`default_nettype none

module reconnect_backoff_fsm_tb import rbf_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE_WAIT  = 4;

	class backoff_tracker;
		logic [DELAY_W-1:0] base_ms;
		logic [DELAY_W-1:0] max_ms;
		link_state_t        state;
		logic [RETRY_W-1:0] retry_cnt;
		logic [NOW_W-1:0]   deadline;
		rbf_result_t        pending_results[$];
		int                 mismatches;
		int                 n_ticks;
		int                 n_checked;
		int                 n_connects;
		int                 n_drops;
		int                 peak_retry;

		function new();
			base_ms    = BASE_DELAY_RST;
			max_ms     = MAX_DELAY_RST;
			state      = ST_DISCONNECTED;
			retry_cnt  = '0;
			deadline   = '0;
			mismatches = 0;
			n_ticks    = 0;
			n_checked  = 0;
			n_connects = 0;
			n_drops    = 0;
			peak_retry = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_BASE_DELAY) begin
				base_ms = data;
			end else if (idx == REG_MAX_DELAY) begin
				max_ms = data;
			end
		endfunction

		function logic [DELAY_W-1:0] backoff_delay(logic [RETRY_W-1:0] tries);
			logic [31:0] scaled;
			scaled = {16'h0, base_ms} << tries;
			if (base_ms == '0) begin
				return '0;
			end else if (tries >= 8'd16) begin
				return max_ms;
			end else if (scaled < {16'h0, max_ms}) begin
				return scaled[DELAY_W-1:0];
			end
			return max_ms;
		endfunction

		function void note_tick(logic [NOW_W-1:0] now, logic ok, logic up);
			rbf_result_t r;
			r = '0;
			n_ticks++;
			case (state)
				ST_DISCONNECTED: begin
					if (now >= deadline) state = ST_CONNECTING;
				end
				ST_CONNECTING: begin
					r.attempt_used = 1'b1;
					if (ok) begin
						state     = ST_CONNECTED;
						retry_cnt = '0;
						deadline  = '0;
						r.became_connected = 1'b1;
						n_connects++;
					end else begin
						if (retry_cnt != RETRY_MAX) retry_cnt++;
						r.delay_ms = backoff_delay(retry_cnt);
						deadline   = now + NOW_W'(r.delay_ms);
						state      = ST_FAILED;
					end
				end
				ST_CONNECTED: begin
					if (!up) begin
						r.delay_ms  = backoff_delay(retry_cnt);
						deadline    = now + NOW_W'(r.delay_ms);
						state       = ST_DISCONNECTED;
						r.link_lost = 1'b1;
						n_drops++;
					end
				end
				default: begin
					if (now >= deadline) state = ST_DISCONNECTED;
				end
			endcase
			if (int'(retry_cnt) > peak_retry) peak_retry = int'(retry_cnt);
			r.link_state    = state;
			r.retries       = retry_cnt;
			r.wait_until_ms = deadline;
			pending_results.push_back(r);
		endfunction

		function void report(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endfunction

		function void check_field(string name, longint unsigned got, longint unsigned exp);
			if (got != exp) begin
				report($sformatf("result %0d field %s got 0x%0h exp 0x%0h",
					n_checked, name, got, exp));
			end
		endfunction

		function void check_result(rbf_result_t got);
			rbf_result_t exp;
			if (pending_results.size() == 0) begin
				report($sformatf("result with no tick pending: 0x%0h", got));
				return;
			end
			exp = pending_results.pop_front();
			check_field("link_state", got.link_state, exp.link_state);
			check_field("retries", got.retries, exp.retries);
			check_field("attempt_used", got.attempt_used, exp.attempt_used);
			check_field("became_connected", got.became_connected, exp.became_connected);
			check_field("link_lost", got.link_lost, exp.link_lost);
			check_field("wait_until_ms", got.wait_until_ms, exp.wait_until_ms);
			check_field("delay_ms", got.delay_ms, exp.delay_ms);
			n_checked++;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	rbf_result_t           seen_result;
	backoff_tracker        tracker = new();
	logic [NOW_W-1:0]      clock_ms;
	int                    quiet_left;
	int                    cycle_cnt;

	rbf_in_if  tick_ch();
	rbf_out_if res_ch();

	reconnect_backoff_fsm dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_ch),
		.result   (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always_comb begin
		seen_result.link_state       = link_state_t'(res_ch.link_state);
		seen_result.retries          = res_ch.retries;
		seen_result.attempt_used     = res_ch.attempt_used;
		seen_result.became_connected = res_ch.became_connected;
		seen_result.link_lost        = res_ch.link_lost;
		seen_result.wait_until_ms    = res_ch.wait_until_ms;
		seen_result.delay_ms         = res_ch.delay_ms;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready) begin
				tracker.note_tick(tick_ch.now_ms, tick_ch.connect_ok, tick_ch.link_up);
			end
			if (res_ch.valid && res_ch.ready) tracker.check_result(seen_result);
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("cycle limit of %0d reached", LIMIT_CYCLES);
		$display("TEST FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if (r < 3) begin
			quiet_left = 50;
			return 0;
		end
		if (r < 48) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int  lo_len;
		int  hi_len;
		int  r;
		bit  held;
		res_ch.ready <= 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && tracker.n_ticks >= 100) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (r < 50) lo_len = 0;
				else if (r < 90) lo_len = $urandom_range(1, 3);
				else if (r < 97) lo_len = $urandom_range(4, 12);
				else lo_len = $urandom_range(20, 60);
				if (lo_len > 0) begin
					res_ch.ready <= 1'b0;
					repeat (lo_len) @(posedge clk);
				end
			end
			hi_len = ($urandom_range(0, 99) < 10) ? $urandom_range(150, 250)
				: $urandom_range(1, 20);
			res_ch.ready <= 1'b1;
			repeat (hi_len) @(posedge clk);
		end
	end

	task automatic send_tick(logic [NOW_W-1:0] now, logic ok, logic up);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.now_ms     <= now;
		tick_ch.connect_ok <= ok;
		tick_ch.link_up    <= up;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	task automatic drain_results();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic apply_setting(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] ceil);
		wr_en    <= 1'b1;
		wr_index <= REG_BASE_DELAY;
		wr_data  <= base;
		@(posedge clk);
		tracker.set_reg(REG_BASE_DELAY, base);
		wr_index <= REG_MAX_DELAY;
		wr_data  <= ceil;
		@(posedge clk);
		tracker.set_reg(REG_MAX_DELAY, ceil);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int count, int ok_pct, int up_pct);
		int               r;
		logic [NOW_W-1:0] now;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				clock_ms = clock_ms + NOW_W'($urandom_range(65536, 70000));
				now = clock_ms;
			end else if (r < 75) begin
				clock_ms = clock_ms + NOW_W'($urandom_range(0, 3000));
				now = clock_ms;
			end else if (r < 85) begin
				now = '1;
			end else begin
				now = $urandom;
			end
			send_tick(now, $urandom_range(0, 99) < ok_pct, $urandom_range(0, 99) < up_pct);
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		wr_en              <= 1'b0;
		wr_index           <= '0;
		wr_data            <= '0;
		tick_ch.valid      <= 1'b0;
		tick_ch.now_ms     <= '0;
		tick_ch.connect_ok <= 1'b0;
		tick_ch.link_up    <= 1'b0;
		quiet_left = 0;
		clock_ms   = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(32'd0, 1'b1, 1'b1);
		send_tick(32'd0, 1'b1, 1'b1);
		send_tick(32'd5, 1'b0, 1'b1);
		send_tick(32'd10, 1'b1, 1'b0);
		send_tick(32'd2009, 1'b1, 1'b1);
		send_tick(32'd2010, 1'b0, 1'b1);
		send_tick(32'd2010, 1'b0, 1'b1);
		send_tick(32'd6009, 1'b1, 1'b0);
		send_tick(32'd6010, 1'b1, 1'b1);
		send_tick(32'd6010, 1'b1, 1'b1);
		send_tick(32'hFFFF_F000, 1'b0, 1'b1);
		send_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_tick(32'd0, 1'b1, 1'b1);
		send_tick(32'hFFFF_FFFF, 1'b0, 1'b0);
		send_tick(32'd0, 1'b1, 1'b1);
		send_tick(32'hFFFF_FFFF, 1'b1, 1'b0);
		run_random(250, 40, 85);

		drain_results();
		apply_setting(16'd65535, 16'd1);
		run_random(150, 40, 70);

		drain_results();
		apply_setting(16'd1, 16'd65535);
		run_random(1100, 0, 85);
		run_random(100, 50, 80);

		drain_results();
		apply_setting(16'd0, 16'd100);
		run_random(120, 40, 70);

		drain_results();
		apply_setting(16'd300, 16'd0);
		run_random(120, 40, 70);

		drain_results();
		apply_setting(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		run_random(200, 40, 85);

		drain_results();
		repeat (8) @(posedge clk);
		if (tracker.pending_results.size() != 0) begin
			tracker.report($sformatf("%0d results never arrived",
				tracker.pending_results.size()));
		end
		$display("Ran %0d ticks over six register settings, %0d results checked.",
			tracker.n_ticks, tracker.n_checked);
		$display("Saw %0d connects, %0d link drops, peak retry count %0d.",
			tracker.n_connects, tracker.n_drops, tracker.peak_retry);
		if (tracker.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
